### rtl/mqrx_pkg.sv
// Shared types and constants for the MQTT receive parser with keepalive timer.
`default_nettype none
package mqrx_pkg;

   localparam int unsigned IDLE_W   = 26;
   localparam int unsigned LEN_W    = 28;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 26;

   localparam logic [IDLE_W-1:0] IDLE_MAX      = 26'h3FF_FFFF;
   localparam logic [IDLE_W-1:0] KEEPALIVE_RST = 26'd15000;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEPALIVE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM    = 1'd1;

   localparam logic [3:0] TYPE_CONNACK  = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
   localparam logic [3:0] TYPE_PUBREC   = 4'd5;
   localparam logic [3:0] TYPE_PINGREQ  = 4'd12;
   localparam logic [3:0] TYPE_PINGRESP = 4'd13;

   typedef enum logic [1:0] {
      FN_BYTE  = 2'd0,
      FN_TICK  = 2'd1,
      FN_SENT  = 2'd2,
      FN_RESET = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      EV_TOPIC   = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_HEADER  = 3'd2,
      EV_PING    = 3'd3,
      EV_EXPIRED = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ACK_NONE     = 3'd0,
      ACK_PUBACK   = 3'd1,
      ACK_PUBREC   = 3'd2,
      ACK_PUBREL   = 3'd3,
      ACK_PINGRESP = 3'd4
   } ack_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_LENGTH = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  data_byte;
      logic        end_of_packet;
      logic [3:0]  packet_type;
      logic [1:0]  qos_level;
      logic        retain_flag;
      logic [15:0] message_id;
      logic [15:0] topic_length;
      ack_type     ack;
      logic        oversize;
      logic [7:0]  return_code;
   } rsp_type;

   // parser -> keepalive
   typedef struct packed {
      logic done_ok;
      logic pingresp_ok;
   } pkt_sts_type;

   // keepalive -> top
   typedef struct packed {
      logic ping;
      logic expire;
   } ka_evt_type;

endpackage
`default_nettype wire

### rtl/mqrx_req_if.sv
// Input channel: function code and received byte.
`default_nettype none
interface mqrx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/mqrx_rsp_if.sv
// Result channel: parsed event beat.
`default_nettype none
interface mqrx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  data_byte;
   logic        end_of_packet;
   logic [3:0]  packet_type;
   logic [1:0]  qos_level;
   logic        retain_flag;
   logic [15:0] message_id;
   logic [15:0] topic_length;
   logic [2:0]  ack_type;
   logic        oversize;
   logic [7:0]  return_code;

   modport source (output valid, output event_res, output data_byte, output end_of_packet,
                   output packet_type, output qos_level, output retain_flag,
                   output message_id, output topic_length, output ack_type,
                   output oversize, output return_code, input ready);
   modport sink   (input valid, input event_res, input data_byte, input end_of_packet,
                   input packet_type, input qos_level, input retain_flag,
                   input message_id, input topic_length, input ack_type,
                   input oversize, input return_code, output ready);
endinterface
`default_nettype wire

### rtl/mqrx_parser.sv
// Packet parser: fixed header, remaining length, publish topic/payload split.
`default_nettype none
module mqrx_parser import mqrx_pkg::*; #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_en,
   input  wire logic        clear_en,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        stream_mode,
   output rsp_type          res,
   output pkt_sts_type      sts
);

   phase_type         phase_ff, phase_in;
   logic [7:0]        header_ff, header_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;
   logic [2:0]        lcnt_ff, lcnt_in;   // length bytes seen, 0..4
   logic [LEN_W-1:0]  bcnt_ff, bcnt_in;
   logic [15:0]       tlen_ff, tlen_in;
   logic [15:0]       msgid_ff, msgid_in;

   always_comb begin
      logic [7:0]       hdr;
      logic             finish;
      logic             done;
      logic [4:0]       shamt;
      logic [LEN_W-1:0] tl2;
      logic [LEN_W-1:0] tl4;
      logic [LEN_W:0]   total;
      logic             ovs;
      logic [1:0]       qos;

      phase_in  = phase_ff;
      header_in = header_ff;
      rlen_in   = rlen_ff;
      lcnt_in   = lcnt_ff;
      bcnt_in   = bcnt_ff;
      tlen_in   = tlen_ff;
      msgid_in  = msgid_ff;
      res       = '0;
      res.event_res = EV_HEADER;
      res.data_byte = rx_byte;
      sts       = '0;
      finish    = 1'b0;
      done      = 1'b0;
      hdr       = header_ff;
      shamt     = {lcnt_ff[1:0], 3'b000} - {2'b00, lcnt_ff};   // 7 * count
      tl2       = {12'd0, tlen_ff} + 28'd2;
      tl4       = {12'd0, tlen_ff} + 28'd4;
      qos       = (header_ff[2:1] == 2'b11) ? 2'b00 : header_ff[2:1];

      unique case (phase_ff)
         PH_LENGTH: begin
            if (lcnt_ff < 3'd4) begin
               rlen_in = rlen_ff | ({21'd0, rx_byte[6:0]} << shamt);
            end
            lcnt_in = lcnt_ff + 3'd1;
            done    = !rx_byte[7] || (lcnt_in == 3'd4);
            if (done) begin
               if (rlen_in == '0) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (header_ff[7:4] == TYPE_PUBLISH) begin
               if (bcnt_ff == 28'd0) begin
                  tlen_in = {rx_byte, 8'h00};
               end else if (bcnt_ff == 28'd1) begin
                  tlen_in = tlen_ff | {8'h00, rx_byte};
               end else if (bcnt_ff < tl2) begin
                  res.event_res = EV_TOPIC;
               end else if (qos != 2'b00 && bcnt_ff < tl4) begin
                  if (bcnt_ff == tl2) begin
                     msgid_in = {rx_byte, 8'h00};
                  end else begin
                     msgid_in = msgid_ff | {8'h00, rx_byte};
                  end
               end else begin
                  res.event_res = EV_PAYLOAD;
               end
            end else begin
               if (bcnt_ff == 28'd0) begin
                  msgid_in = {rx_byte, 8'h00};
               end else if (bcnt_ff == 28'd1) begin
                  msgid_in = msgid_ff | {8'h00, rx_byte};
               end
            end
            bcnt_in = bcnt_ff + 28'd1;
            if (bcnt_in >= rlen_ff) begin
               finish = 1'b1;
            end
         end
         default: begin
            // header byte; an illegal phase code lands here too
            hdr       = rx_byte;
            header_in = rx_byte;
            rlen_in   = '0;
            lcnt_in   = '0;
            bcnt_in   = '0;
            tlen_in   = '0;
            msgid_in  = '0;
            phase_in  = PH_LENGTH;
         end
      endcase

      res.packet_type = hdr[7:4];
      if (hdr[7:4] == TYPE_PUBLISH) begin
         res.qos_level   = (hdr[2:1] == 2'b11) ? 2'b00 : hdr[2:1];
         res.retain_flag = hdr[0];
      end

      total = {1'b0, rlen_in} + {26'd0, lcnt_in} + 29'd1;
      ovs   = !stream_mode && (total > 29'(MAX_PACKET));

      if (finish) begin
         phase_in          = PH_HEADER;
         res.end_of_packet = 1'b1;
         res.oversize      = ovs;
         if (header_ff[7:4] == TYPE_PUBLISH) begin
            res.topic_length = tlen_in;
         end
         if (header_ff[7:4] == TYPE_CONNACK) begin
            res.return_code = msgid_in[7:0];
         end
         if (!ovs) begin
            sts.done_ok = byte_en;
            if (header_ff[7:4] == TYPE_PUBLISH) begin
               if (qos == 2'd1) begin
                  res.ack = ACK_PUBACK;
               end else if (qos == 2'd2) begin
                  res.ack = ACK_PUBREC;
               end
            end else if (header_ff[7:4] == TYPE_PUBREC) begin
               res.ack = ACK_PUBREL;
            end else if (header_ff[7:4] == TYPE_PINGREQ) begin
               res.ack = ACK_PINGRESP;
            end else if (header_ff[7:4] == TYPE_PINGRESP) begin
               sts.pingresp_ok = byte_en;
            end
            if (res.ack == ACK_PUBACK || res.ack == ACK_PUBREC || res.ack == ACK_PUBREL) begin
               res.message_id = msgid_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         rlen_ff   <= '0;
         lcnt_ff   <= '0;
         bcnt_ff   <= '0;
         tlen_ff   <= '0;
         msgid_ff  <= '0;
      end else if (byte_en) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         rlen_ff   <= rlen_in;
         lcnt_ff   <= lcnt_in;
         bcnt_ff   <= bcnt_in;
         tlen_ff   <= tlen_in;
         msgid_ff  <= msgid_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mqrx_keepalive.sv
// Keepalive timer: saturating idle counters, ping request and expiry.
`default_nettype none
module mqrx_keepalive import mqrx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick_en,
   input  wire logic              sent_en,
   input  wire logic              clear_en,
   input  wire logic [IDLE_W-1:0] keepalive_ticks,
   input  wire pkt_sts_type       sts,
   output ka_evt_type             evt
);

   logic [IDLE_W-1:0] idle_in_ff, idle_in_in;
   logic [IDLE_W-1:0] idle_out_ff, idle_out_in;
   logic              ping_ff, ping_in;

   always_comb begin
      logic [IDLE_W-1:0] in_inc;
      logic [IDLE_W-1:0] out_inc;
      logic              timeout;

      in_inc  = (idle_in_ff == IDLE_MAX) ? idle_in_ff : idle_in_ff + 26'd1;
      out_inc = (idle_out_ff == IDLE_MAX) ? idle_out_ff : idle_out_ff + 26'd1;
      timeout = (in_inc > keepalive_ticks) || (out_inc > keepalive_ticks);

      idle_in_in  = idle_in_ff;
      idle_out_in = idle_out_ff;
      ping_in     = ping_ff;
      evt         = '0;

      priority if (clear_en) begin
         idle_in_in  = '0;
         idle_out_in = '0;
         ping_in     = 1'b0;
      end else if (tick_en) begin
         if (timeout) begin
            // expiry clears the session; a fresh timeout sends a ping
            idle_in_in  = '0;
            idle_out_in = '0;
            ping_in     = !ping_ff;
            evt.ping    = !ping_ff;
            evt.expire  = ping_ff;
         end else begin
            idle_in_in  = in_inc;
            idle_out_in = out_inc;
         end
      end else if (sent_en) begin
         idle_out_in = '0;
      end else begin
         if (sts.done_ok) begin
            idle_in_in = '0;
         end
         if (sts.pingresp_ok) begin
            ping_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_in_ff  <= '0;
         idle_out_ff <= '0;
         ping_ff     <= 1'b0;
      end else begin
         idle_in_ff  <= idle_in_in;
         idle_out_ff <= idle_out_in;
         ping_ff     <= ping_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mqtt_receive_parser_keepalive_core.sv
// MQTT receive parser with keepalive timer: one beat in, at most one beat out.
// A result is registered and appears on rsp in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless a held result stalls req; the parser and timer state update at accept,
// and the output register takes a new result in the same cycle the old one drains.
// Reset (synchronous, active high) clears parser, timer and output valid, and loads
// keepalive_ticks = 15000 and stream_mode = 0.
`default_nettype none
module mqtt_receive_parser_keepalive_core import mqrx_pkg::*; #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mqrx_req_if.sink                  req_bus,
   mqrx_rsp_if.source                rsp_bus,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wr_data
);

   logic [IDLE_W-1:0] keepalive_ff, keepalive_in;
   logic              stream_ff, stream_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic        accept;
   func_type    func;
   logic        byte_en, tick_en, sent_en, reset_en;
   rsp_type     parse_res;
   pkt_sts_type pkt_sts;
   ka_evt_type  ka_evt;
   logic        load;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept  = req_bus.valid && req_bus.ready;
   assign func    = func_type'(req_bus.func);
   assign byte_en  = accept && (func == FN_BYTE);
   assign tick_en  = accept && (func == FN_TICK);
   assign sent_en  = accept && (func == FN_SENT);
   assign reset_en = accept && (func == FN_RESET);

   mqrx_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (byte_en),
      .clear_en    (reset_en || ka_evt.expire),
      .rx_byte     (req_bus.rx_byte),
      .stream_mode (stream_ff),
      .res         (parse_res),
      .sts         (pkt_sts)
   );

   mqrx_keepalive u_keepalive (
      .clock           (clock),
      .reset           (reset),
      .tick_en         (tick_en),
      .sent_en         (sent_en),
      .clear_en        (reset_en),
      .keepalive_ticks (keepalive_ff),
      .sts             (pkt_sts),
      .evt             (ka_evt)
   );

   // configuration writes
   always_comb begin
      keepalive_in = keepalive_ff;
      stream_in    = stream_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEEPALIVE: keepalive_in = csr_wr_data;
            CSR_STREAM:    stream_in    = csr_wr_data[0];
         endcase
      end
   end

   // output register
   always_comb begin
      load        = byte_en || ka_evt.ping || ka_evt.expire;
      rsp_data_in = rsp_data_ff;
      if (byte_en) begin
         rsp_data_in = parse_res;
      end else if (load) begin
         rsp_data_in = '0;
         rsp_data_in.event_res = ka_evt.expire ? EV_EXPIRED : EV_PING;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keepalive_ff <= KEEPALIVE_RST;
         stream_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keepalive_ff <= keepalive_in;
         stream_ff    <= stream_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.event_res     = rsp_data_ff.event_res;
   assign rsp_bus.data_byte     = rsp_data_ff.data_byte;
   assign rsp_bus.end_of_packet = rsp_data_ff.end_of_packet;
   assign rsp_bus.packet_type   = rsp_data_ff.packet_type;
   assign rsp_bus.qos_level     = rsp_data_ff.qos_level;
   assign rsp_bus.retain_flag   = rsp_data_ff.retain_flag;
   assign rsp_bus.message_id    = rsp_data_ff.message_id;
   assign rsp_bus.topic_length  = rsp_data_ff.topic_length;
   assign rsp_bus.ack_type      = rsp_data_ff.ack;
   assign rsp_bus.oversize      = rsp_data_ff.oversize;
   assign rsp_bus.return_code   = rsp_data_ff.return_code;

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the MQTT receive parser and keepalive timer.
module testbench;
   import mqrx_pkg::*;

   localparam int unsigned MAX_PKT = 128;

   typedef struct packed {
      func_type   fn;
      logic [7:0] value;
   } req_beat_type;

   typedef logic [7:0] byte_q_type [$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   mqrx_req_if req_bus ();
   mqrx_rsp_if rsp_bus ();

   logic                 drv_valid = 1'b0;
   logic [1:0]           drv_func = 2'd0;
   logic [7:0]           drv_byte = 8'd0;
   logic                 rcv_ready = 1'b0;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wr_data = '0;

   assign req_bus.valid   = drv_valid;
   assign req_bus.func    = drv_func;
   assign req_bus.rx_byte = drv_byte;
   assign rsp_bus.ready   = rcv_ready;

   mqtt_receive_parser_keepalive_core #(.MAX_PACKET(MAX_PKT)) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   req_beat_type beats_to_send [$];
   rsp_type      events_due [$];
   int unsigned  beats_queued = 0;
   int unsigned  mismatches = 0;

   // traffic shaping knobs, set between phases
   logic tx_idle_on = 1'b0;
   logic rx_idle_on = 1'b0;
   logic long_hold_arm = 1'b0;
   logic long_hold_done = 1'b0;

   // ---------------------------------------------------------------- predictor state
   logic [IDLE_W-1:0] ka_ticks;
   logic              stream_on;
   phase_type         ph;
   logic [7:0]        hdr_q;
   logic [LEN_W-1:0]  rem_len;
   logic [4:0]        len_shift;
   logic [LEN_W-1:0]  byte_cnt;
   logic [15:0]       topic_len_q;
   logic [15:0]       msg_id_q;
   logic              ping_out;
   logic [IDLE_W-1:0] idle_in_q;
   logic [IDLE_W-1:0] idle_out_q;

   function automatic void clear_session();
      ph = PH_HEADER;
      hdr_q = '0;
      rem_len = '0;
      len_shift = '0;
      byte_cnt = '0;
      topic_len_q = '0;
      msg_id_q = '0;
      ping_out = 1'b0;
      idle_in_q = '0;
      idle_out_q = '0;
   endfunction

   // reserved QoS 3 is treated as QoS 0
   function automatic logic [1:0] qos_of(input logic [7:0] hdr);
      return (hdr[2:1] == 2'd3) ? 2'd0 : hdr[2:1];
   endfunction

   function automatic rsp_type with_kind(input rsp_type ev, input logic [7:0] hdr);
      rsp_type k;
      k = ev;
      k.packet_type = hdr[7:4];
      if (hdr[7:4] == TYPE_PUBLISH) begin
         k.qos_level = qos_of(hdr);
         k.retain_flag = hdr[0];
      end
      return k;
   endfunction

   function automatic rsp_type close_packet(input rsp_type ev);
      rsp_type     k;
      logic [31:0] total;
      logic        ovs;
      k = ev;
      total = 32'd1 + 32'(len_shift) / 32'd7 + 32'(rem_len);
      ovs = !stream_on && (total > MAX_PKT);
      ph = PH_HEADER;
      k.end_of_packet = 1'b1;
      k.oversize = ovs;
      if (hdr_q[7:4] == TYPE_PUBLISH) k.topic_length = topic_len_q;
      if (hdr_q[7:4] == TYPE_CONNACK) k.return_code = msg_id_q[7:0];
      if (!ovs) begin
         idle_in_q = '0;
         if (hdr_q[7:4] == TYPE_PUBLISH) begin
            if (qos_of(hdr_q) == 2'd1) k.ack = ACK_PUBACK;
            else if (qos_of(hdr_q) == 2'd2) k.ack = ACK_PUBREC;
         end else if (hdr_q[7:4] == TYPE_PUBREC) begin
            k.ack = ACK_PUBREL;
         end else if (hdr_q[7:4] == TYPE_PINGREQ) begin
            k.ack = ACK_PINGRESP;
         end else if (hdr_q[7:4] == TYPE_PINGRESP) begin
            ping_out = 1'b0;
         end
         if (k.ack == ACK_PUBACK || k.ack == ACK_PUBREC || k.ack == ACK_PUBREL)
            k.message_id = msg_id_q;
      end
      return k;
   endfunction

   // Advances the parser/timer copy by one accepted beat; returns 1 when a result is due.
   function automatic bit decode_beat(input func_type fn, input logic [7:0] b,
                                      output rsp_type ev);
      logic [31:0] pos;
      logic [31:0] tl;
      ev = '0;
      case (fn)
         FN_BYTE: begin
            ev.data_byte = b;
            ev.event_res = EV_HEADER;
            if (ph == PH_LENGTH) begin
               ev = with_kind(ev, hdr_q);
               if (len_shift < 5'd28) rem_len = rem_len | (LEN_W'(b[6:0]) << len_shift);
               len_shift = len_shift + 5'd7;
               // fourth length byte closes the field regardless of its top bit
               if (!b[7] || len_shift >= 5'd28) begin
                  if (rem_len == '0) ev = close_packet(ev);
                  else ph = PH_BODY;
               end
            end else if (ph == PH_BODY) begin
               pos = 32'(byte_cnt);
               tl = 32'(topic_len_q);
               ev = with_kind(ev, hdr_q);
               if (hdr_q[7:4] == TYPE_PUBLISH) begin
                  if (pos == 0) topic_len_q = {b, 8'h00};
                  else if (pos == 1) topic_len_q = topic_len_q | 16'(b);
                  else if (pos < 2 + tl) ev.event_res = EV_TOPIC;
                  else if (qos_of(hdr_q) != 2'd0 && pos < 4 + tl) begin
                     if (pos == 2 + tl) msg_id_q = {b, 8'h00};
                     else msg_id_q = msg_id_q | 16'(b);
                  end else ev.event_res = EV_PAYLOAD;
               end else begin
                  if (pos == 0) msg_id_q = {b, 8'h00};
                  else if (pos == 1) msg_id_q = msg_id_q | 16'(b);
               end
               byte_cnt = byte_cnt + 1'b1;
               if (byte_cnt >= rem_len) ev = close_packet(ev);
            end else begin
               hdr_q = b;
               rem_len = '0;
               len_shift = '0;
               byte_cnt = '0;
               topic_len_q = '0;
               msg_id_q = '0;
               ph = PH_LENGTH;
               ev = with_kind(ev, b);
            end
            return 1'b1;
         end
         FN_TICK: begin
            if (idle_in_q != IDLE_MAX) idle_in_q = idle_in_q + 1'b1;
            if (idle_out_q != IDLE_MAX) idle_out_q = idle_out_q + 1'b1;
            if (idle_in_q > ka_ticks || idle_out_q > ka_ticks) begin
               if (ping_out) begin
                  clear_session();
                  ev.event_res = EV_EXPIRED;
               end else begin
                  idle_in_q = '0;
                  idle_out_q = '0;
                  ping_out = 1'b1;
                  ev.event_res = EV_PING;
               end
               return 1'b1;
            end
            return 1'b0;
         end
         FN_SENT: begin
            idle_out_q = '0;
            return 1'b0;
         end
         default: begin
            clear_session();
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- idling
   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ---------------------------------------------------------------- driver
   int unsigned  tx_gap_left = 0;
   req_beat_type tx_next;

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         tx_gap_left <= 0;
      end else if (!drv_valid || req_bus.ready) begin
         if (tx_gap_left != 0) begin
            drv_valid <= 1'b0;
            tx_gap_left <= tx_gap_left - 1;
         end else if (beats_to_send.size() != 0) begin
            tx_next = beats_to_send.pop_front();
            drv_valid <= 1'b1;
            drv_func <= tx_next.fn;
            drv_byte <= tx_next.value;
            tx_gap_left <= tx_idle_on ? random_gap() : 0;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   int unsigned rx_stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rcv_ready <= 1'b0;
         rx_stall_left <= 0;
      end else if (long_hold_arm && !long_hold_done) begin
         // one long back-pressure stretch so the block fills and stalls req
         long_hold_done <= 1'b1;
         rx_stall_left <= 400;
         rcv_ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rx_stall_left <= rx_stall_left - 1;
         rcv_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(99) < 20) begin
         rx_stall_left <= random_gap();
         rcv_ready <= 1'b0;
      end else begin
         rcv_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor / checker
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%s mismatch: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   rsp_type want_ev;
   rsp_type new_ev;

   always @(posedge clock) begin
      if (reset) begin
         ka_ticks = KEEPALIVE_RST;
         stream_on = 1'b0;
         clear_session();
         events_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_KEEPALIVE) ka_ticks = csr_wr_data;
            else if (csr_index == CSR_STREAM) stream_on = csr_wr_data[0];
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (events_due.size() == 0) begin
               report("unexpected beat, event_res", 32'(rsp_bus.event_res), 0);
            end else begin
               want_ev = events_due.pop_front();
               if (rsp_bus.event_res !== want_ev.event_res)
                  report("event_res", 32'(rsp_bus.event_res), 32'(want_ev.event_res));
               if (rsp_bus.data_byte !== want_ev.data_byte)
                  report("data_byte", 32'(rsp_bus.data_byte), 32'(want_ev.data_byte));
               if (rsp_bus.end_of_packet !== want_ev.end_of_packet)
                  report("end_of_packet", 32'(rsp_bus.end_of_packet),
                         32'(want_ev.end_of_packet));
               if (rsp_bus.packet_type !== want_ev.packet_type)
                  report("packet_type", 32'(rsp_bus.packet_type), 32'(want_ev.packet_type));
               if (rsp_bus.qos_level !== want_ev.qos_level)
                  report("qos_level", 32'(rsp_bus.qos_level), 32'(want_ev.qos_level));
               if (rsp_bus.retain_flag !== want_ev.retain_flag)
                  report("retain_flag", 32'(rsp_bus.retain_flag), 32'(want_ev.retain_flag));
               if (rsp_bus.message_id !== want_ev.message_id)
                  report("message_id", 32'(rsp_bus.message_id), 32'(want_ev.message_id));
               if (rsp_bus.topic_length !== want_ev.topic_length)
                  report("topic_length", 32'(rsp_bus.topic_length), 32'(want_ev.topic_length));
               if (rsp_bus.ack_type !== want_ev.ack)
                  report("ack_type", 32'(rsp_bus.ack_type), 32'(want_ev.ack));
               if (rsp_bus.oversize !== want_ev.oversize)
                  report("oversize", 32'(rsp_bus.oversize), 32'(want_ev.oversize));
               if (rsp_bus.return_code !== want_ev.return_code)
                  report("return_code", 32'(rsp_bus.return_code), 32'(want_ev.return_code));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (decode_beat(func_type'(req_bus.func), req_bus.rx_byte, new_ev))
               events_due.push_back(new_ev);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_beat(input func_type fn, input logic [7:0] value);
      req_beat_type bt;
      bt.fn = fn;
      bt.value = value;
      beats_to_send.push_back(bt);
      beats_queued++;
   endtask

   task automatic push_packet(input logic [7:0] hdr, input byte_q_type body, input bit chatter);
      int unsigned rem;
      logic [7:0]  lb;
      rem = body.size();
      push_beat(FN_BYTE, hdr);
      do begin
         lb = 8'(rem % 128);
         rem = rem / 128;
         if (rem != 0) lb[7] = 1'b1;
         push_beat(FN_BYTE, lb);
      end while (rem != 0);
      foreach (body[i]) begin
         // ticks and sent notices can land in the middle of a packet
         if (chatter && $urandom_range(11) == 0)
            push_beat(func_type'($urandom_range(2, 1)), 8'($urandom));
         push_beat(FN_BYTE, body[i]);
      end
   endtask

   task automatic push_random_packet(input bit chatter);
      byte_q_type  body;
      logic [7:0]  hdr;
      int unsigned roll;
      int unsigned tl;
      int unsigned cut;
      roll = $urandom_range(99);
      hdr = 8'($urandom);
      if (roll < 45) hdr[7:4] = TYPE_PUBLISH;
      else if (roll < 55) hdr[7:4] = TYPE_PUBREC;
      else if (roll < 63) hdr[7:4] = TYPE_PINGREQ;
      else if (roll < 73) hdr[7:4] = TYPE_PINGRESP;
      else if (roll < 83) hdr[7:4] = TYPE_CONNACK;
      if (hdr[7:4] == TYPE_PUBLISH) begin
         tl = $urandom_range(6);
         body.push_back(8'(tl >> 8));
         body.push_back(8'(tl));
         repeat (tl) body.push_back(8'($urandom));
         if (hdr[2:1] == 2'd1 || hdr[2:1] == 2'd2) repeat (2) body.push_back(8'($urandom));
         repeat (($urandom_range(19) == 0) ? $urandom_range(190, 115) : $urandom_range(8))
            body.push_back(8'($urandom));
      end else begin
         repeat (($urandom_range(19) == 0) ? $urandom_range(190, 120) : $urandom_range(4))
            body.push_back(8'($urandom));
      end
      // short packet: body ends before its fields are complete
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(body.size());
         repeat (cut) body.delete(body.size() - 1);
         if (body.size() >= 2) begin
            body[0] = 8'($urandom);
            body[1] = 8'($urandom);
         end
      end
      push_packet(hdr, body, chatter);
   endtask

   task automatic run_traffic(input int unsigned count);
      int unsigned start;
      int unsigned roll;
      start = beats_queued;
      while (beats_queued - start < count) begin
         roll = $urandom_range(99);
         if (roll < 72) begin
            push_random_packet($urandom_range(1));
         end else if (roll < 80) begin
            // broken sequence: a few stray bytes, then the session is reset
            repeat ($urandom_range(4, 1)) push_beat(FN_BYTE, 8'($urandom));
            push_beat(FN_RESET, 8'($urandom));
         end else begin
            repeat ($urandom_range(5)) push_beat(FN_TICK, 8'($urandom));
            if ($urandom_range(2) == 0) push_beat(FN_SENT, 8'($urandom));
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DAT_W-1:0] ka, input logic stream,
                            input logic tx_idle, input logic rx_idle);
      write_reg(CSR_KEEPALIVE, ka);
      // only bit 0 of the stream register matters
      write_reg(CSR_STREAM, {25'($urandom), stream});
      tx_idle_on <= tx_idle;
      rx_idle_on <= rx_idle;
   endtask

   task automatic settle();
      while (beats_to_send.size() != 0 || drv_valid || events_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   logic [9:0] opening_beats [$] = '{
      // QoS 1 retained PUBLISH, empty topic, id FFFF -> PUBACK
      {FN_BYTE, 8'h33}, {FN_BYTE, 8'h05}, {FN_BYTE, 8'h00}, {FN_BYTE, 8'h00},
      {FN_BYTE, 8'hFF}, {FN_BYTE, 8'hFF}, {FN_BYTE, 8'h00},
      // PINGREQ with zero length ends on its length byte
      {FN_BYTE, 8'hC0}, {FN_BYTE, 8'h00},
      // PUBREC cut short after the high id byte
      {FN_BYTE, 8'h50}, {FN_BYTE, 8'h01}, {FN_BYTE, 8'hAA},
      // reserved QoS 3 publish with one topic byte
      {FN_BYTE, 8'h36}, {FN_BYTE, 8'h03}, {FN_BYTE, 8'h00}, {FN_BYTE, 8'h01},
      {FN_BYTE, 8'h41},
      // four length bytes all flagged as continued
      {FN_BYTE, 8'h30}, {FN_BYTE, 8'h80}, {FN_BYTE, 8'h80}, {FN_BYTE, 8'h80},
      {FN_BYTE, 8'h80},
      // keepalive of one tick: ping, PINGRESP, ping, sent, expiry, session reset
      {FN_TICK, 8'hFF}, {FN_TICK, 8'h00}, {FN_BYTE, 8'hD0}, {FN_BYTE, 8'h00},
      {FN_TICK, 8'h00}, {FN_TICK, 8'hFF}, {FN_SENT, 8'h5A}, {FN_TICK, 8'hA5},
      {FN_TICK, 8'h00}, {FN_RESET, 8'hFF}
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      configure(26'd1, 1'b0, 1'b1, 1'b1);
      foreach (opening_beats[i])
         push_beat(func_type'(opening_beats[i][9:8]), opening_beats[i][7:0]);
      settle();

      configure(26'd22, 1'b0, 1'b1, 1'b1);
      run_traffic(300);
      settle();

      // long keepalive below the largest, oversize kept, no idling on either side
      configure(26'd65535000, 1'b1, 1'b0, 1'b0);
      run_traffic(250);
      settle();

      configure(26'h01803E0 >> 16, 1'b0, 1'b1, 1'b1);
      long_hold_arm <= 1'b1;
      run_traffic(250);
      settle();

      configure(26'd5, 1'b1, 1'b1, 1'b1);
      run_traffic(250);
      settle();

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
